// ----- sv/pbtb_pkg.sv -----
`default_nettype none
package pbtb_pkg;

  localparam int CoordW = 18;
  typedef logic signed [CoordW-1:0] coord_t;

  localparam int VpDimCap = 512;
  localparam int ResultCap = 64;
  localparam int CntW = $clog2(ResultCap);
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 64;

  typedef enum logic [CfgIdxW-1:0] {
    REG_VIEWPORT = 3'd0,
    REG_SC_EN    = 3'd1,
    REG_SCISSOR  = 3'd2,
    REG_FB_W     = 3'd3,
    REG_FB_H     = 3'd4
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_CLIP_VP,
    ST_CLIP_SC,
    ST_EMIT
  } state_t;

  typedef struct packed {
    coord_t x0;
    coord_t y0;
    coord_t x1;
    coord_t y1;
  } box_t;

  typedef struct packed {
    logic               req_type;
    logic signed [15:0] v0_x;
    logic signed [15:0] v0_y;
    logic signed [15:0] v1_x;
    logic signed [15:0] v1_y;
    logic signed [15:0] v2_x;
    logic signed [15:0] v2_y;
    logic [31:0]        depth;
    logic [31:0]        color_rgba;
    logic [15:0]        point_size;
  } req_t;

  typedef struct packed {
    logic signed [11:0] tile_x0;
    logic signed [11:0] tile_y0;
    logic signed [11:0] tile_x1;
    logic signed [11:0] tile_y1;
    logic [31:0]        color_out;
    logic [31:0]        depth_out;
    logic               is_sprite;
    logic signed [15:0] sprite_center_x;
    logic signed [15:0] sprite_center_y;
    logic [15:0]        sprite_diam;
    logic               last_tile;
  } tile_t;

  function automatic coord_t sext16(input logic [15:0] v);
    sext16 = coord_t'(signed'(v));
  endfunction

  function automatic coord_t zext16(input logic [15:0] v);
    zext16 = coord_t'({2'b00, v});
  endfunction

  // 12.4 to whole pixels, truncating toward zero
  function automatic coord_t to_pix(input coord_t f);
    coord_t m;
    m = -f;
    if (f < 0) begin
      to_pix = -(m >>> 4);
    end else begin
      to_pix = f >>> 4;
    end
  endfunction

  function automatic coord_t cmin(input coord_t a, input coord_t b);
    cmin = (a < b) ? a : b;
  endfunction

  function automatic coord_t cmax(input coord_t a, input coord_t b);
    cmax = (a > b) ? a : b;
  endfunction

endpackage
`default_nettype wire

// ----- sv/pbtb_if.sv -----
`default_nettype none
interface pbtb_req_if import pbtb_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface pbtb_tile_if import pbtb_pkg::*; ();
  logic  valid;
  logic  ready;
  tile_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- sv/pbtb_clip.sv -----
`default_nettype none
module pbtb_clip import pbtb_pkg::*; (
  input  box_t box,
  input  box_t lim,
  output box_t res,
  output logic empty
);

  always_comb begin
    res.x0 = cmax(box.x0, lim.x0);
    res.y0 = cmax(box.y0, lim.y0);
    res.x1 = cmin(box.x1, lim.x1);
    res.y1 = cmin(box.y1, lim.y1);
    empty  = (res.x0 > res.x1) || (res.y0 > res.y1);
  end

endmodule
`default_nettype wire

// ----- sv/primitive_bbox_tile_binner_top.sv -----
// Primitive bounding-box tile binner.
// req: one primitive word per handshake (valid/ready), triangle or point sprite.
// tile: one clipped screen tile word per handshake, last_tile on the final one.
// cfg_wen/cfg_index/cfg_wdata: register writes; issue them only while idle.
// A primitive goes through setup, then viewport clip and scissor clip in one
// shared clamp unit, one pass per cycle (the scissor result is used only with
// scissor on). The walker then loads one tile per cycle while the output
// register is free or being read: at most 64 tiles, none when the box is
// empty. The next request is taken as soon as the last tile is loaded,
// even while that tile still waits in the output register.
// A stalled tile receiver holds the output register and freezes the walker.
// Reset (rst, synchronous) empties the output register, returns the sequencer
// to idle and loads the register defaults (512x512 viewport and scissor,
// scissor off, 512x512 framebuffer).
`default_nettype none
module primitive_bbox_tile_binner_top import pbtb_pkg::*; #(
  parameter int TILE_EDGE  = 64,
  parameter int MAX_FB_DIM = 512
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wen,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_wdata,
  pbtb_req_if.sink            req,
  pbtb_tile_if.source         tile
);

  localparam logic [63:0] RectReset = 64'd144117387099111424;
  localparam coord_t TileStep = coord_t'(TILE_EDGE);
  localparam coord_t FbCap = coord_t'(MAX_FB_DIM);
  localparam coord_t VpCap = coord_t'(VpDimCap);
  localparam coord_t One = coord_t'(1);

  logic [63:0] vp_rect;
  logic        sc_en;
  logic [63:0] sc_rect;
  logic [9:0]  fb_w;
  logic [9:0]  fb_h;

  always_ff @(posedge clk) begin
    if (rst) begin
      vp_rect <= RectReset;
      sc_en   <= 1'b0;
      sc_rect <= RectReset;
      fb_w    <= 10'd512;
      fb_h    <= 10'd512;
    end else if (cfg_wen) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_VIEWPORT: vp_rect <= cfg_wdata;
        REG_SC_EN:    sc_en   <= cfg_wdata[0];
        REG_SCISSOR:  sc_rect <= cfg_wdata;
        REG_FB_W:     fb_w    <= cfg_wdata[9:0];
        REG_FB_H:     fb_h    <= cfg_wdata[9:0];
        default: ;
      endcase
    end
  end

  state_t state, state_next;
  req_t   prim;
  box_t   box;
  coord_t tx, ty;
  logic [CntW-1:0] n;
  logic   out_valid;
  tile_t  out_data;

  // raw box
  box_t   raw;
  coord_t cx, cy, half;
  always_comb begin
    cx   = sext16(prim.v0_x);
    cy   = sext16(prim.v0_y);
    half = coord_t'({3'b000, prim.point_size[15:5], 4'b0000});
    if (prim.req_type) begin
      raw.x0 = to_pix(cx - half);
      raw.y0 = to_pix(cy - half);
      raw.x1 = to_pix(cx + half);
      raw.y1 = to_pix(cy + half);
    end else begin
      raw.x0 = to_pix(cmin(cx, cmin(sext16(prim.v1_x), sext16(prim.v2_x))));
      raw.x1 = to_pix(cmax(cx, cmax(sext16(prim.v1_x), sext16(prim.v2_x))));
      raw.y0 = to_pix(cmin(cy, cmin(sext16(prim.v1_y), sext16(prim.v2_y))));
      raw.y1 = to_pix(cmax(cy, cmax(sext16(prim.v1_y), sext16(prim.v2_y))));
    end
  end

  // clamp limits for the shared clip unit
  box_t   lim;
  coord_t vx, vy, vw, vh, sx, sy, sx1, sy1, fw, fh;
  always_comb begin
    vx  = sext16(vp_rect[15:0]);
    vy  = sext16(vp_rect[31:16]);
    vw  = cmin(zext16(vp_rect[47:32]), VpCap);
    vh  = cmin(zext16(vp_rect[63:48]), VpCap);
    fw  = cmin(coord_t'({8'd0, fb_w}), FbCap);
    fh  = cmin(coord_t'({8'd0, fb_h}), FbCap);
    sx  = sext16(sc_rect[15:0]);
    sy  = sext16(sc_rect[31:16]);
    sx1 = sx + zext16(sc_rect[47:32]) - One;
    sy1 = sy + zext16(sc_rect[63:48]) - One;
    if (state == ST_CLIP_VP) begin
      lim.x0 = vx;
      lim.y0 = vy;
      lim.x1 = vx + vw - One;
      lim.y1 = vy + vh - One;
    end else begin
      lim.x0 = cmax(sx, '0);
      lim.y0 = cmax(sy, '0);
      lim.x1 = (sx1 >= fw) ? fw - One : sx1;
      lim.y1 = (sy1 >= fh) ? fh - One : sy1;
    end
  end

  box_t clip_res;
  logic clip_empty;
  pbtb_clip u_clip (
    .box   (box),
    .lim   (lim),
    .res   (clip_res),
    .empty (clip_empty)
  );

  box_t final_box;
  logic final_empty;
  always_comb begin
    final_box   = sc_en ? clip_res : box;
    final_empty = sc_en ? clip_empty : ((box.x0 > box.x1) || (box.y0 > box.y1));
  end

  // tile walker
  coord_t tx_end, ty_end;
  logic   row_done, col_done, last;
  always_comb begin
    tx_end   = tx + TileStep - One;
    ty_end   = ty + TileStep - One;
    row_done = tx_end >= box.x1;
    col_done = ty_end >= box.y1;
    last     = (row_done && col_done) || (n == CntW'(ResultCap - 1));
  end

  logic emit;
  always_comb begin
    state_next = state;
    req.ready  = 1'b0;
    emit       = 1'b0;
    unique case (state)
      ST_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) state_next = ST_SETUP;
      end
      ST_SETUP:   state_next = ST_CLIP_VP;
      ST_CLIP_VP: state_next = ST_CLIP_SC;
      ST_CLIP_SC: state_next = final_empty ? ST_IDLE : ST_EMIT;
      ST_EMIT: begin
        emit = !out_valid || tile.ready;
        if (emit && last) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) prim <= req.data;
    unique case (state)
      ST_SETUP:   box <= raw;
      ST_CLIP_VP: box <= clip_res;
      ST_CLIP_SC: begin
        box <= final_box;
        tx  <= final_box.x0;
        ty  <= final_box.y0;
        n   <= '0;
      end
      ST_EMIT: begin
        if (emit) begin
          n <= n + CntW'(1);
          if (row_done) begin
            tx <= box.x0;
            ty <= ty + TileStep;
          end else begin
            tx <= tx + TileStep;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (tile.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data.tile_x0         <= tx[11:0];
      out_data.tile_y0         <= ty[11:0];
      out_data.tile_x1         <= row_done ? box.x1[11:0] : tx_end[11:0];
      out_data.tile_y1         <= col_done ? box.y1[11:0] : ty_end[11:0];
      out_data.color_out       <= prim.color_rgba;
      out_data.depth_out       <= prim.depth;
      out_data.is_sprite       <= prim.req_type;
      out_data.sprite_center_x <= prim.req_type ? prim.v0_x : '0;
      out_data.sprite_center_y <= prim.req_type ? prim.v0_y : '0;
      out_data.sprite_diam     <= prim.req_type ? prim.point_size : '0;
      out_data.last_tile       <= last;
    end
  end

  assign tile.valid = out_valid;
  assign tile.data  = out_data;

endmodule
`default_nettype wire

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
module tb import pbtb_pkg::*; ();

  localparam int TileEdge = 64;
  localparam int MaxFbDim = 512;
  localparam int CycleLimit = 2000000;
  localparam int SettleCycles = 10;
  localparam logic [63:0] RectDefault = 64'h0200_0200_0000_0000;

  logic                clk;
  logic                rst;
  logic                cfg_wen;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_wdata;

  pbtb_req_if  req_bus ();
  pbtb_tile_if tile_bus ();

  primitive_bbox_tile_binner_top #(
    .TILE_EDGE (TileEdge),
    .MAX_FB_DIM(MaxFbDim)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_wen  (cfg_wen),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .req      (req_bus),
    .tile     (tile_bus)
  );

  logic [63:0] vp_rect;
  logic [63:0] sc_rect;
  logic        sc_en;
  logic [9:0]  fb_w;
  logic [9:0]  fb_h;

  tile_t pending_tiles[$];
  int    err_count = 0;
  int    cycles = 0;
  int    src_idle_pct = 25;
  int    sink_idle_pct = 68;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    tile_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      tile_bus.ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // 12.4 fixed to whole pixels, toward zero
  function automatic int to_px(input int f);
    if (f < 0) return -((-f) >>> 4);
    return f >>> 4;
  endfunction

  function automatic int imin(input int a, input int b);
    return (a < b) ? a : b;
  endfunction

  function automatic int imax(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

  function automatic void bin_primitive(input req_t r);
    int    cx, cy, bx, by, qx, qy, half;
    int    x0, y0, x1, y1;
    int    vx, vy, vw, vh;
    int    sx, sy, sx1, sy1, fw, fh;
    int    tx, ty, n;
    tile_t t;
    cx = r.v0_x;
    cy = r.v0_y;
    if (r.req_type) begin
      half = int'(r.point_size >> 5) * 16;
      x0 = to_px(cx - half);
      y0 = to_px(cy - half);
      x1 = to_px(cx + half);
      y1 = to_px(cy + half);
    end else begin
      bx = r.v1_x;
      by = r.v1_y;
      qx = r.v2_x;
      qy = r.v2_y;
      x0 = to_px(imin(cx, imin(bx, qx)));
      x1 = to_px(imax(cx, imax(bx, qx)));
      y0 = to_px(imin(cy, imin(by, qy)));
      y1 = to_px(imax(cy, imax(by, qy)));
    end

    vx = signed'(vp_rect[15:0]);
    vy = signed'(vp_rect[31:16]);
    vw = imin(int'(vp_rect[47:32]), VpDimCap);
    vh = imin(int'(vp_rect[63:48]), VpDimCap);
    x0 = imax(x0, vx);
    y0 = imax(y0, vy);
    x1 = imin(x1, vx + vw - 1);
    y1 = imin(y1, vy + vh - 1);

    if (sc_en) begin
      sx = signed'(sc_rect[15:0]);
      sy = signed'(sc_rect[31:16]);
      sx1 = sx + int'(sc_rect[47:32]) - 1;
      sy1 = sy + int'(sc_rect[63:48]) - 1;
      fw = imin(int'(fb_w), MaxFbDim);
      fh = imin(int'(fb_h), MaxFbDim);
      sx = imax(sx, 0);
      sy = imax(sy, 0);
      sx1 = imin(sx1, fw - 1);
      sy1 = imin(sy1, fh - 1);
      x0 = imax(x0, sx);
      y0 = imax(y0, sy);
      x1 = imin(x1, sx1);
      y1 = imin(y1, sy1);
    end

    if (x0 > x1 || y0 > y1) return;

    n = 0;
    for (ty = y0; ty <= y1 && n < ResultCap; ty += TileEdge) begin
      for (tx = x0; tx <= x1 && n < ResultCap; tx += TileEdge) begin
        t.tile_x0 = tx[11:0];
        t.tile_y0 = ty[11:0];
        t.tile_x1 = 12'(imin(tx + TileEdge - 1, x1));
        t.tile_y1 = 12'(imin(ty + TileEdge - 1, y1));
        t.color_out = r.color_rgba;
        t.depth_out = r.depth;
        t.is_sprite = r.req_type;
        t.sprite_center_x = r.req_type ? r.v0_x : 16'sd0;
        t.sprite_center_y = r.req_type ? r.v0_y : 16'sd0;
        t.sprite_diam = r.req_type ? r.point_size : 16'd0;
        t.last_tile = (tx + TileEdge > x1 && ty + TileEdge > y1) || n == ResultCap - 1;
        pending_tiles.push_back(t);
        n++;
      end
    end
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      err_count++;
    end
  endtask

  always @(posedge clk) begin : tile_checker
    tile_t want;
    tile_t got;
    if (!rst && tile_bus.valid && tile_bus.ready) begin
      got = tile_bus.data;
      if (pending_tiles.size() == 0) begin
        $error("unexpected tile word: %h", got);
        err_count++;
      end else begin
        want = pending_tiles.pop_front();
        check_field("tile_x0", want.tile_x0, got.tile_x0);
        check_field("tile_y0", want.tile_y0, got.tile_y0);
        check_field("tile_x1", want.tile_x1, got.tile_x1);
        check_field("tile_y1", want.tile_y1, got.tile_y1);
        check_field("color_out", want.color_out, got.color_out);
        check_field("depth_out", want.depth_out, got.depth_out);
        check_field("is_sprite", want.is_sprite, got.is_sprite);
        check_field("sprite_center_x", want.sprite_center_x, got.sprite_center_x);
        check_field("sprite_center_y", want.sprite_center_y, got.sprite_center_y);
        check_field("sprite_diam", want.sprite_diam, got.sprite_diam);
        check_field("last_tile", want.last_tile, got.last_tile);
      end
    end
  end

  task automatic send_prim(input req_t r);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      req_bus.valid <= 1'b0;
      @(negedge clk);
    end
    req_bus.valid <= 1'b1;
    req_bus.data <= r;
    @(posedge clk);
    while (!req_bus.ready) @(posedge clk);
    bin_primitive(r);
  endtask

  task automatic drain_tiles();
    @(negedge clk);
    req_bus.valid <= 1'b0;
    while (pending_tiles.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [63:0] val);
    @(negedge clk);
    cfg_wen <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_wen <= 1'b0;
    case (idx)
      REG_VIEWPORT: vp_rect = val;
      REG_SC_EN:    sc_en = val[0];
      REG_SCISSOR:  sc_rect = val;
      REG_FB_W:     fb_w = val[9:0];
      REG_FB_H:     fb_h = val[9:0];
      default: ;
    endcase
  endtask

  function automatic req_t tri_prim(input logic [15:0] ax, input logic [15:0] ay,
                                    input logic [15:0] bx, input logic [15:0] by,
                                    input logic [15:0] qx, input logic [15:0] qy);
    req_t r;
    r.req_type = 1'b0;
    r.v0_x = ax;
    r.v0_y = ay;
    r.v1_x = bx;
    r.v1_y = by;
    r.v2_x = qx;
    r.v2_y = qy;
    r.depth = $urandom;
    r.color_rgba = $urandom;
    r.point_size = 16'($urandom);
    return r;
  endfunction

  function automatic req_t point_prim(input logic [15:0] cx, input logic [15:0] cy,
                                      input logic [15:0] size);
    req_t r;
    r = tri_prim(cx, cy, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    r.req_type = 1'b1;
    r.point_size = size;
    return r;
  endfunction

  function automatic logic [15:0] pick_coord();
    if ($urandom_range(9) == 0) return 16'($urandom);
    return 16'($urandom_range(11264) - 1024);
  endfunction

  function automatic logic [15:0] near_coord(input logic [15:0] c);
    if ($urandom_range(9) == 0) return 16'($urandom);
    return c + 16'($urandom_range(3072)) - 16'd1536;
  endfunction

  function automatic req_t rand_prim();
    req_t r;
    r.req_type = 1'($urandom_range(1));
    r.v0_x = pick_coord();
    r.v0_y = pick_coord();
    r.v1_x = near_coord(r.v0_x);
    r.v1_y = near_coord(r.v0_y);
    r.v2_x = near_coord(r.v0_x);
    r.v2_y = near_coord(r.v0_y);
    r.depth = $urandom;
    r.color_rgba = $urandom;
    r.point_size = ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(2047));
    return r;
  endfunction

  task automatic rand_config();
    logic [63:0] vp;
    logic [63:0] sc;
    if ($urandom_range(5) == 0) vp = {$urandom, $urandom};
    else vp = {16'($urandom_range(600)), 16'($urandom_range(600)),
               16'($urandom_range(192) - 64), 16'($urandom_range(192) - 64)};
    if ($urandom_range(5) == 0) sc = {$urandom, $urandom};
    else sc = {16'($urandom_range(600)), 16'($urandom_range(600)),
               16'($urandom_range(464) - 64), 16'($urandom_range(464) - 64)};
    write_reg(REG_VIEWPORT, vp);
    write_reg(REG_SC_EN, 64'($urandom_range(1)));
    write_reg(REG_SCISSOR, sc);
    write_reg(REG_FB_W, ($urandom_range(7) == 0) ? 64'($urandom_range(1023))
                                                 : 64'($urandom_range(512, 64)));
    write_reg(REG_FB_H, ($urandom_range(7) == 0) ? 64'($urandom_range(1023))
                                                 : 64'($urandom_range(512, 64)));
  endtask

  task automatic test_reset_defaults();
    send_prim(tri_prim(16'h8000, 16'h8000, 16'h7FFF, 16'h0000, 16'h0000, 16'h7FFF));
    send_prim(tri_prim(16'd160, 16'd320, 16'd1120, 16'd480, 16'd640, 16'd1440));
    send_prim(tri_prim(16'hFFF1, 16'hFFF1, 16'd15, 16'hFFF1, 16'd0, 16'd15));
  endtask

  task automatic test_triangle_extremes();
    send_prim(tri_prim(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000));
    send_prim(tri_prim(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF));
    send_prim(tri_prim(16'd800, 16'd900, 16'd100, 16'd5000, 16'd3000, 16'd50));
    send_prim(tri_prim(16'hFE00, 16'd2000, 16'd1500, 16'hFF00, 16'd40, 16'd3333));
  endtask

  task automatic test_point_sprites();
    send_prim(point_prim(16'd160, 16'd160, 16'd0));
    send_prim(point_prim(16'd160, 16'd160, 16'd31));
    send_prim(point_prim(16'd160, 16'd160, 16'd32));
    send_prim(point_prim(16'd4000, 16'd4000, 16'hFFFF));
    send_prim(point_prim(16'h8000, 16'h8000, 16'hFFFF));
    send_prim(point_prim(16'h7FFF, 16'h0000, 16'h1000));
  endtask

  task automatic test_viewport_clip();
    drain_tiles();
    write_reg(REG_VIEWPORT, {16'hFFFF, 16'hFFFF, 16'hF800, 16'hF800});
    send_prim(tri_prim(16'hFFE1, 16'hFFE1, 16'hFFEF, 16'd5, 16'hFE0C, 16'hFF9C));
    send_prim(point_prim(16'h8000, 16'h8000, 16'hFFFF));
    drain_tiles();
    write_reg(REG_VIEWPORT, {16'd512, 16'd512, 16'd1900, 16'd1900});
    send_prim(point_prim(16'h7FFF, 16'h7FFF, 16'hFFFF));
    drain_tiles();
    write_reg(REG_VIEWPORT, {16'd512, 16'd0, 16'd0, 16'd0});
    send_prim(tri_prim(16'h8000, 16'h8000, 16'h7FFF, 16'h0000, 16'h0000, 16'h7FFF));
    drain_tiles();
    write_reg(REG_VIEWPORT, RectDefault);
  endtask

  task automatic test_scissor_clip();
    drain_tiles();
    write_reg(REG_SC_EN, 64'd1);
    write_reg(REG_SCISSOR, {16'd300, 16'd300, 16'hFFD8, 16'd100});
    write_reg(REG_FB_W, 64'd1023);
    write_reg(REG_FB_H, 64'd200);
    send_prim(tri_prim(16'h8000, 16'h8000, 16'h7FFF, 16'h0000, 16'h0000, 16'h7FFF));
    drain_tiles();
    write_reg(REG_FB_W, 64'd0);
    send_prim(tri_prim(16'h8000, 16'h8000, 16'h7FFF, 16'h0000, 16'h0000, 16'h7FFF));
    drain_tiles();
    write_reg(REG_FB_W, 64'd512);
    write_reg(REG_SCISSOR, {16'd300, 16'd0, 16'd0, 16'd0});
    send_prim(tri_prim(16'h8000, 16'h8000, 16'h7FFF, 16'h0000, 16'h0000, 16'h7FFF));
    drain_tiles();
    write_reg(REG_SCISSOR, {16'hFFFF, 16'hFFFF, 16'h8000, 16'h8000});
    write_reg(REG_FB_H, 64'd1);
    send_prim(tri_prim(16'h8000, 16'h8000, 16'h7FFF, 16'h0000, 16'h0000, 16'h7FFF));
    drain_tiles();
    write_reg(REG_SC_EN, 64'd0);
    write_reg(REG_SCISSOR, RectDefault);
    write_reg(REG_FB_W, 64'd512);
    write_reg(REG_FB_H, 64'd512);
  endtask

  task automatic test_random_traffic(input int src_pct, input int sink_pct, input int count);
    src_idle_pct = src_pct;
    sink_idle_pct = sink_pct;
    for (int i = 0; i < count; i++) begin
      if (i % 36 == 0) begin
        drain_tiles();
        rand_config();
      end
      send_prim(rand_prim());
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_wen = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    req_bus.valid = 1'b0;
    req_bus.data = '0;
    vp_rect = RectDefault;
    sc_rect = RectDefault;
    sc_en = 1'b0;
    fb_w = 10'd512;
    fb_h = 10'd512;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_triangle_extremes();
    test_point_sprites();
    test_viewport_clip();
    test_scissor_clip();
    test_random_traffic(25, 68, 100);
    test_random_traffic(68, 25, 100);
    test_random_traffic(0, 0, 100);
    drain_tiles();

    if (err_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/pbtb_pkg.sv
sv/pbtb_if.sv
sv/pbtb_clip.sv
sv/primitive_bbox_tile_binner_top.sv
sim/tb.sv
